### design/gnri_pkg.sv
// ---------------------------------------------------------------------------
// gnri_pkg
// Shared types and constants for the greedy no-repeat interleaver.
// ---------------------------------------------------------------------------
package gnri_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int LW           = 5;   // letter / heap position width
  localparam int CW           = 11;  // count and length width
  localparam logic [7:0] CHAR_A = 8'h61;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_UP, S_POPCHK, S_DOWN, S_DEC, S_HELD, S_COMMIT, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    build_start;
    logic    scan_inc;
    logic    scan_push;
    logic    push_held;
    logic    up_step;
    logic    pop_start;
    logic    down_step;
    logic    dec;
    logic    emit;
    status_t kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic loading;
    logic overflowed;
    logic len_zero;
    logic scan_end;
    logic scan_nz;
    logic up_done;
    logic heap_empty;
    logic down_done;
    logic held_live;
    logic out_busy;
  } sts_t;

endpackage

### design/gnri_ctrl.sv
// ---------------------------------------------------------------------------
// gnri_ctrl
// Sequencer for load, heap build, pop/sift-down, push/sift-up and result.
// ---------------------------------------------------------------------------
module gnri_ctrl import gnri_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_op,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t  state_r, state_nxt;
  logic    ret_scan_r, ret_scan_nxt;
  status_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_scan_r <= 1'b0;
      kind_r     <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      ret_scan_r <= ret_scan_nxt;
      kind_r     <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_scan_nxt = ret_scan_r;
    kind_nxt     = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_op) begin
          if (!sts.loading) begin
            state_nxt = S_POPCHK;
          end else if (sts.overflowed) begin
            kind_nxt  = ST_FAIL;
            state_nxt = S_OUT;
          end else if (sts.len_zero) begin
            kind_nxt  = ST_EMPTY;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_POPCHK;
        end else if (sts.scan_nz) begin
          ret_scan_nxt = 1'b1;
          state_nxt    = S_UP;
        end
      end
      S_UP: begin
        if (sts.up_done) state_nxt = ret_scan_r ? S_SCAN : S_COMMIT;
      end
      S_POPCHK: begin
        if (sts.heap_empty) begin
          kind_nxt  = ST_FAIL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DOWN;
        end
      end
      S_DOWN: begin
        if (sts.down_done) state_nxt = S_DEC;
      end
      S_DEC:  state_nxt = S_HELD;
      S_HELD: begin
        if (sts.held_live) begin
          ret_scan_nxt = 1'b0;
          state_nxt    = S_UP;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        kind_nxt  = ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = kind_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.load        = in_fire && !in_op;
        cmd.build_start = in_fire && in_op && sts.loading && !sts.overflowed
                          && !sts.len_zero;
      end
      S_SCAN: begin
        cmd.scan_push = !sts.scan_end && sts.scan_nz;
        cmd.scan_inc  = !sts.scan_end && !sts.scan_nz;
      end
      S_UP:     cmd.up_step   = 1'b1;
      S_POPCHK: cmd.pop_start = !sts.heap_empty;
      S_DOWN:   cmd.down_step = 1'b1;
      S_DEC:    cmd.dec       = 1'b1;
      S_HELD:   cmd.push_held = sts.held_live;
      S_COMMIT: ;
      S_OUT:    cmd.emit      = !sts.out_busy;
      default:  ;
    endcase
  end

endmodule

### design/gnri_dp.sv
// ---------------------------------------------------------------------------
// gnri_dp
// Letter counts, heap storage, sift steps and the result register.
// ---------------------------------------------------------------------------
module gnri_dp import gnri_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] in_symbol,
  input  logic       out_ready,
  output sts_t       sts,
  output logic       out_valid,
  output logic [7:0] out_symbol,
  output status_t    out_status,
  output logic       out_last
);

  logic [CW-1:0] cnt_r [ALPHABET];
  logic [LW-1:0] heap_r [ALPHABET];
  logic [LW-1:0] size_r, pos_r, scan_r, held_r, popped_r;
  logic          held_v_r, phase_r, ovf_r;
  logic [CW-1:0] total_r, emit_r;
  logic          ov_r;
  logic [7:0]    osym_r;
  status_t       ost_r;
  logic          olast_r;

  logic [7:0]    rel;
  logic          is_letter;
  logic [LW-1:0] parent, best;
  logic [LW:0]   lch, rch;
  logic          greater, last_now, clr;
  logic [CW-1:0] c_pos, c_par, c_l, c_r, c_best;

  assign rel       = in_symbol - CHAR_A;
  assign is_letter = (in_symbol >= CHAR_A) && ({24'd0, rel} < ALPHABET);

  assign parent  = (pos_r - LW'(1)) >> 1;
  assign c_pos   = cnt_r[heap_r[pos_r]];
  assign c_par   = cnt_r[heap_r[parent]];
  assign greater = (pos_r != '0) && (c_pos > c_par);

  assign lch = {pos_r, 1'b1};
  assign rch = {pos_r, 1'b0} + (LW+1)'(2);
  assign c_l = (lch < {1'b0, size_r}) ? cnt_r[heap_r[lch[LW-1:0]]] : '0;
  assign c_r = (rch < {1'b0, size_r}) ? cnt_r[heap_r[rch[LW-1:0]]] : '0;

  // left child first, each replaces only when strictly greater
  always_comb begin
    best   = pos_r;
    c_best = c_pos;
    if (lch < {1'b0, size_r} && c_l > c_best) begin
      best   = lch[LW-1:0];
      c_best = c_l;
    end
    if (rch < {1'b0, size_r} && c_r > c_best) best = rch[LW-1:0];
  end

  assign last_now = (cmd.kind != ST_OK) || ({1'b0, emit_r} + 12'd1 >= {1'b0, total_r});
  assign clr      = cmd.emit && last_now;

  assign sts.loading    = !phase_r;
  assign sts.overflowed = ovf_r;
  assign sts.len_zero   = (total_r == '0);
  assign sts.scan_end   = ({27'd0, scan_r} >= ALPHABET);
  assign sts.scan_nz    = !sts.scan_end && (cnt_r[scan_r] != '0);
  assign sts.up_done    = !greater;
  assign sts.heap_empty = (size_r == '0);
  assign sts.down_done  = (best == pos_r);
  assign sts.held_live  = held_v_r && (cnt_r[held_r] != '0);
  assign sts.out_busy   = ov_r && !out_ready;

  // heap storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.scan_push) heap_r[size_r] <= scan_r;
    if (cmd.push_held) heap_r[size_r] <= held_r;
    if (cmd.up_step && greater) begin
      heap_r[pos_r]  <= heap_r[parent];
      heap_r[parent] <= heap_r[pos_r];
    end
    if (cmd.pop_start) heap_r[0] <= heap_r[size_r - LW'(1)];
    if (cmd.down_step && best != pos_r) begin
      heap_r[pos_r] <= heap_r[best];
      heap_r[best]  <= heap_r[pos_r];
    end
    if (cmd.pop_start) popped_r <= heap_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < ALPHABET; i++) cnt_r[i] <= '0;
      size_r   <= '0;
      pos_r    <= '0;
      scan_r   <= '0;
      held_r   <= '0;
      held_v_r <= 1'b0;
      phase_r  <= 1'b0;
      ovf_r    <= 1'b0;
      total_r  <= '0;
      emit_r   <= '0;
    end else begin
      // loads while emitting are dropped
      if (cmd.load && !phase_r) begin
        if ({21'd0, total_r} >= MAX_LEN) begin
          ovf_r <= 1'b1;
        end else begin
          total_r <= total_r + CW'(1);
          if (is_letter) cnt_r[rel[LW-1:0]] <= cnt_r[rel[LW-1:0]] + CW'(1);
        end
      end
      if (cmd.build_start) begin
        size_r   <= '0;
        scan_r   <= '0;
        held_v_r <= 1'b0;
        emit_r   <= '0;
        phase_r  <= 1'b1;
      end
      if (cmd.scan_inc) scan_r <= scan_r + LW'(1);
      if (cmd.scan_push || cmd.push_held) begin
        pos_r  <= size_r;
        size_r <= size_r + LW'(1);
      end
      if (cmd.scan_push) scan_r <= scan_r + LW'(1);
      if (cmd.up_step && greater) pos_r <= parent;
      if (cmd.pop_start) begin
        size_r <= size_r - LW'(1);
        pos_r  <= '0;
      end
      if (cmd.down_step) pos_r <= best;
      if (cmd.dec && cnt_r[popped_r] != '0) cnt_r[popped_r] <= cnt_r[popped_r] - CW'(1);
      if (cmd.emit && cmd.kind == ST_OK) begin
        held_r   <= popped_r;
        held_v_r <= 1'b1;
        emit_r   <= emit_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      osym_r  <= (cmd.kind == ST_OK) ? CHAR_A + {3'd0, popped_r} : 8'd0;
      ost_r   <= cmd.kind;
      olast_r <= last_now;
    end
  end

  assign out_valid  = ov_r;
  assign out_symbol = osym_r;
  assign out_status = ost_r;
  assign out_last   = olast_r;

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {27'd0, size_r} <= ALPHABET) else $error("heap size beyond alphabet");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (total_r == '0) && !phase_r) else $error("state not cleared");
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.kind != ST_OK |=> out_last && out_symbol == 8'd0)
    else $error("failure result not terminal");
`endif

endmodule

### design/greedy_no_repeat_interleaver.sv
// ---------------------------------------------------------------------------
// greedy_no_repeat_interleaver
// Rearranges loaded letters so that no letter repeats, most frequent first.
// ---------------------------------------------------------------------------
// in_tuser = 0 loads the byte in in_tdata; in_tuser = 1 asks for the next
// symbol. Loads give no transaction on the out channel.
// A request gives one out transaction: out_tdata is the letter, out_tuser
// the status (ok, empty string, no valid arrangement), out_tlast marks the
// final symbol or a failure. The first request builds the heap by scanning
// all letters and sifting each present letter up; every request then pops
// the top by sift-down and sifts the held letter back up, one compare per
// step of the single heap step unit.
// in_tready is high only while the sequencer is idle; while a result waits
// on out_tready the next result is held in the output step and in_tready
// stays low until the out register frees.
// Reset and every terminal result clear all counts and the length.
// ---------------------------------------------------------------------------
module greedy_no_repeat_interleaver import gnri_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // symbol
  input  logic       in_tuser,   // operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_symbol
  output logic [1:0] out_tuser,  // status
  output logic       out_tlast
);

  cmd_t    cmd;
  sts_t    sts;
  status_t ost;
  logic    fire;

  assign fire      = in_tvalid && in_tready;
  assign out_tuser = ost;

  gnri_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (fire),
    .in_op    (in_tuser),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  gnri_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_symbol  (in_tdata),
    .out_ready  (out_tready),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_symbol (out_tdata),
    .out_status (ost),
    .out_last   (out_tlast)
  );

endmodule

### bench/greedy_no_repeat_interleaver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// greedy_no_repeat_interleaver_tb
// Drives strings of bytes followed by symbol requests and checks every out
// transaction against a cycle-free predictor of the max-heap greedy scheme.
// ---------------------------------------------------------------------------
module greedy_no_repeat_interleaver_tb;
  import gnri_pkg::*;

  localparam int MAXL  = MAX_LEN_DEF;
  localparam int ALPHA = ALPHABET_DEF;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef struct packed {
    logic [7:0] sym;
    status_t    st;
    logic       last;
  } result_t;

  class arrangement_scoreboard;
    int unsigned cnt[26];
    int unsigned heap[26];
    int unsigned hsize, held, held_v, total, emitted, emitting, ovf;
    result_t pending[$];
    int errors;

    function void clear();
      foreach (cnt[i]) cnt[i] = 0;
      hsize = 0; held = 0; held_v = 0; total = 0;
      emitted = 0; emitting = 0; ovf = 0;
    endfunction

    function void push(int unsigned l);
      int unsigned p, par, t;
      p = hsize;
      heap[p] = l;
      hsize++;
      while (p > 0) begin
        par = (p - 1) / 2;
        if (cnt[heap[p]] > cnt[heap[par]]) begin
          t = heap[p]; heap[p] = heap[par]; heap[par] = t;
          p = par;
        end else break;
      end
    endfunction

    function int unsigned pop();
      int unsigned top, p, b, l, r, t;
      top = heap[0];
      heap[0] = heap[hsize - 1];
      hsize--;
      p = 0;
      forever begin
        b = p; l = 2 * p + 1; r = 2 * p + 2;
        if (l < hsize && cnt[heap[l]] > cnt[heap[b]]) b = l;
        if (r < hsize && cnt[heap[r]] > cnt[heap[b]]) b = r;
        if (b == p) break;
        t = heap[p]; heap[p] = heap[b]; heap[b] = t;
        p = b;
      end
      return top;
    endfunction

    function void finish_with(logic [7:0] s, status_t st, logic lst);
      result_t r;
      r.sym = s; r.st = st; r.last = lst;
      pending.push_back(r);
      if (lst) clear();
    endfunction

    function void note_input(logic op, logic [7:0] s);
      int unsigned l;
      if (op == OP_LOAD) begin
        if (emitting) return;
        if (total >= MAXL) begin
          ovf = 1;
          return;
        end
        total++;
        if (s >= CHAR_A && s <= 8'h7a) cnt[s - CHAR_A]++;
        return;
      end
      if (!emitting) begin
        if (ovf) begin
          finish_with(8'd0, ST_FAIL, 1'b1);
          return;
        end
        if (total == 0) begin
          finish_with(8'd0, ST_EMPTY, 1'b1);
          return;
        end
        hsize = 0;
        for (int i = 0; i < ALPHA; i++) if (cnt[i] != 0) push(i);
        held_v = 0; emitted = 0; emitting = 1;
      end
      if (hsize == 0) begin
        finish_with(8'd0, ST_FAIL, 1'b1);
        return;
      end
      l = pop();
      if (cnt[l] > 0) cnt[l]--;
      if (held_v && cnt[held] > 0) push(held);
      held = l; held_v = 1;
      emitted++;
      finish_with(8'(CHAR_A + l), ST_OK, emitted >= total);
    endfunction

    function void check_result(logic [7:0] s, logic [1:0] st, logic lst);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction sym=%h st=%0d last=%0b", s, st, lst);
        return;
      end
      e = pending.pop_front();
      if (e.sym !== s || e.st !== st || e.last !== lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp sym=%h st=%0d last=%0b got sym=%h st=%0d last=%0b",
                   e.sym, e.st, e.last, s, st, lst);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic [7:0] in_tdata = 0;
  logic in_tready, out_tvalid, out_tlast;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic calm = 0;
  int   cycles = 0;

  arrangement_scoreboard sb = new();

  greedy_no_repeat_interleaver u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, check on every accepted transaction
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // tvalid stays high after an accept until the next call or the end of the run
  task automatic send(logic op, logic [7:0] s);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, s);
  endtask

  task automatic load_letters(int n, int span);
    for (int i = 0; i < n; i++) send(OP_LOAD, 8'(CHAR_A + $urandom_range(0, span - 1)));
  endtask

  // request until the string ends
  task automatic drain_string();
    int guard;
    guard = 0;
    do begin
      send(OP_NEXT, 8'($urandom));
      guard++;
    end while (sb.emitting && guard < 2 * MAXL + 4);
  endtask

  int items;
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty string
    send(OP_NEXT, 8'hff);
    // a single letter, then extremes of the byte range in a failing string
    send(OP_LOAD, 8'h7a);
    drain_string();
    send(OP_LOAD, 8'h00);
    send(OP_LOAD, 8'hff);
    send(OP_LOAD, 8'h61);
    drain_string();
    // repeated letter with an arrangement, then one with none
    send(OP_LOAD, 8'h61); send(OP_LOAD, 8'h61); send(OP_LOAD, 8'h62);
    send(OP_NEXT, 8'h00);
    send(OP_LOAD, 8'h63); // ignored while emitting
    drain_string();
    send(OP_LOAD, 8'h61); send(OP_LOAD, 8'h61);
    drain_string();
    // too long
    for (int i = 0; i < MAXL + 2; i++) send(OP_LOAD, 8'(CHAR_A + (i % 26)));
    send(OP_NEXT, 8'h55);
    items = 0;
    while (items < 1000) begin
      int n, kind;
      kind = $urandom_range(0, 9);
      n = $urandom_range(1, 20);
      if (kind == 0) begin
        for (int i = 0; i < n; i++) send(1'($urandom_range(0, 1)), 8'($urandom));
      end else begin
        load_letters(n, $urandom_range(1, 26));
        if (kind == 1) send(OP_LOAD, 8'($urandom));
        if (kind == 2) send(OP_LOAD, 8'($urandom));
        drain_string();
      end
      items += 2 * n;
      if (items > 800) calm <= 1'b1;
    end
    in_tvalid <= 1'b0;
    begin
      int wait_cycles;
      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 100000) begin
        @(posedge clk);
        wait_cycles++;
      end
      repeat (100) @(posedge clk);
      if (sb.errors == 0 && sb.pending.size() == 0)
        $display("tb: success");
      else
        $display("tb: failure");
      $finish;
    end
  end
endmodule
